/* hw/rtl/spr_pkg.sv */
// Shared codes, widths and the front-to-back command type of the pattern replacer.
package spr_pkg;

    // Input item function codes
    localparam logic [2:0] F_DATA    = 3'd0;
    localparam logic [2:0] F_WR_SRC  = 3'd1;
    localparam logic [2:0] F_WR_REP  = 3'd2;
    localparam logic [2:0] F_WR_LEN  = 3'd3;
    localparam logic [2:0] F_TICK    = 3'd4;

    // Configuration register indexes
    localparam int          CFG_IDX_W         = 2;
    localparam logic [1:0]  REG_PATTERN_COUNT = 2'd0;
    localparam logic [1:0]  REG_TIMEOUT       = 2'd1;

    // Command fields sized for the largest table the block supports
    localparam int PAT_W = 4;
    localparam int LEN_W = 7;

    // One queue entry: either a literal byte or a whole replacement run
    typedef struct packed {
        logic             is_rep;
        logic [7:0]       data;
        logic             tmo;
        logic             last;
        logic [PAT_W-1:0] pat;
        logic [LEN_W-1:0] len;
    } t_cmd;

endpackage

/* hw/rtl/spr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/spr_queue.sv */
// Small command FIFO between the match front end and the output back end.
module spr_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  spr_pkg::t_cmd i_data,
    input  logic          i_pop,
    output spr_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    spr_pkg::t_cmd   r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (int'(r_cnt) == DEPTH);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= (int'(r_wp) == DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= (int'(r_rp) == DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if ((i_push && !o_full) && !(i_pop && !o_empty)) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!(i_push && !o_full) && (i_pop && !o_empty)) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/spr_front.sv */
// Front end: takes input items and config, holds pending bytes, matches suffixes, queues commands.
module spr_front #(
    parameter int NUM_PATTERNS = 4,
    parameter int MAX_LEN      = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input item channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_func,
    input  logic [7:0]             i_data_byte,
    input  logic [1:0]             i_pattern_index,
    input  logic [3:0]             i_byte_index,
    input  logic [4:0]             i_source_length,
    input  logic [4:0]             i_replace_length,
    // configuration writes
    input  logic                   i_cfg_valid,
    input  logic [spr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    // replacement table write port
    output logic                   o_rep_we,
    output logic [$clog2(NUM_PATTERNS*MAX_LEN)-1:0] o_rep_waddr,
    output logic [7:0]             o_rep_wdata,
    // command queue
    output logic                   o_push,
    output spr_pkg::t_cmd          o_cmd,
    input  logic                   i_q_full,
    input  logic                   i_back_idle
);

    localparam int IW  = $clog2(MAX_LEN);
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int PIW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int RAW = $clog2(NUM_PATTERNS * MAX_LEN);
    localparam int PW  = spr_pkg::PAT_W;
    localparam int LW  = spr_pkg::LEN_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MATCH = 3'd1;
    localparam logic [2:0] S_RES   = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_REP   = 3'd5;

    logic [2:0]                             r_state, n_state;
    logic [MAX_LEN-1:0][7:0]                r_buf, n_buf;     // newest byte at index 0
    logic [MAX_LEN-1:0][7:0]                r_win, n_win;     // shifting compare window
    logic [MAX_LEN-1:0][NUM_PATTERNS-1:0]   r_flag, n_flag;   // [size-1][pattern] still matching
    logic [CW-1:0]                          r_cnt, n_cnt;
    logic [CW-1:0]                          r_len, n_len;
    logic [IW-1:0]                          r_j, n_j;
    logic [CW-1:0]                          r_sz, n_sz;
    logic                                   r_found, n_found;
    logic [PIW-1:0]                         r_hit, n_hit;
    logic [CW-1:0]                          r_keep, n_keep;
    logic [CW-1:0]                          r_left, n_left;
    logic [IW-1:0]                          r_idx, n_idx;
    logic                                   r_tmo, n_tmo;
    logic                                   r_rep_pend, n_rep_pend;
    logic [PIW-1:0]                         r_rep_pat, n_rep_pat;
    logic [CW-1:0]                          r_rep_len, n_rep_len;
    logic [15:0]                            r_idle, n_idle;
    logic [2:0]                             r_pc;
    logic [15:0]                            r_tmo_ticks;
    logic [CW-1:0]                          r_slen [NUM_PATTERNS];
    logic [CW-1:0]                          r_rlen [NUM_PATTERNS];

    logic [NUM_PATTERNS-1:0][7:0]           src_row;
    logic [IW-1:0]                          src_raddr;
    logic                                   acc;
    logic                                   tbl_ok;

    assign o_in_ready = (r_state == S_IDLE) && ((i_func != spr_pkg::F_WR_REP) || i_back_idle);
    assign acc        = i_in_valid && o_in_ready;
    assign tbl_ok     = (int'(i_pattern_index) < NUM_PATTERNS) && (int'(i_byte_index) < MAX_LEN);

    // one source RAM per pattern, all read at the same byte position
    for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_src
        spr_ram #(
            .WIDTH (8),
            .DEPTH (MAX_LEN)
        ) u_src_ram (
            .i_clk   (i_clk),
            .i_we    (acc && (i_func == spr_pkg::F_WR_SRC) && tbl_ok &&
                      (int'(i_pattern_index) == g)),
            .i_waddr (IW'(i_byte_index)),
            .i_wdata (i_data_byte),
            .i_re    (1'b1),
            .i_raddr (src_raddr),
            .o_rdata (src_row[g])
        );
    end

    assign src_raddr = (r_state == S_MATCH) ? r_j + 1'b1 : '0;

    // replacement table writes go straight to the back end's RAM
    assign o_rep_we    = acc && (i_func == spr_pkg::F_WR_REP) && tbl_ok;
    assign o_rep_waddr = RAW'(int'(i_pattern_index) * MAX_LEN + int'(i_byte_index));
    assign o_rep_wdata = i_data_byte;

    // main sequencer
    always_comb begin
        logic [16:0]             idle_inc;
        logic [CW-1:0]           nlit;
        logic [CW-1:0]           rl;
        logic [CW-1:0]           newcnt;
        logic                    any_full;
        logic [PIW-1:0]          first_full;
        logic [IW-1:0]           k_sz;
        n_state    = r_state;
        n_buf      = r_buf;
        n_win      = r_win;
        n_flag     = r_flag;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_j        = r_j;
        n_sz       = r_sz;
        n_found    = r_found;
        n_hit      = r_hit;
        n_keep     = r_keep;
        n_left     = r_left;
        n_idx      = r_idx;
        n_tmo      = r_tmo;
        n_rep_pend = r_rep_pend;
        n_rep_pat  = r_rep_pat;
        n_rep_len  = r_rep_len;
        n_idle     = r_idle;
        o_push     = 1'b0;
        o_cmd      = '0;
        idle_inc   = {1'b0, r_idle} + 17'd1;
        nlit       = '0;
        rl         = '0;
        newcnt     = '0;
        any_full   = 1'b0;
        first_full = '0;
        k_sz       = IW'(r_sz - 1'b1);

        case (r_state)
            S_IDLE: begin
                if (acc && (i_func == spr_pkg::F_DATA)) begin
                    // append the byte and arm the suffix flags
                    n_buf[0] = i_data_byte;
                    for (int k = 1; k < MAX_LEN; k++) begin
                        n_buf[k] = r_buf[k-1];
                    end
                    n_win = n_buf;
                    for (int k = 0; k < MAX_LEN; k++) begin
                        for (int p = 0; p < NUM_PATTERNS; p++) begin
                            n_flag[k][p] = (k < int'(r_cnt) + 1) &&
                                           (k + 1 <= int'(r_slen[p])) &&
                                           (p < int'(r_pc));
                        end
                    end
                    n_len   = r_cnt + 1'b1;
                    n_j     = '0;
                    n_state = S_MATCH;
                end else if (acc && (i_func == spr_pkg::F_TICK)) begin
                    if ((r_tmo_ticks == '0) || (r_cnt == '0)) begin
                        n_idle = '0;
                    end else if (idle_inc >= {1'b0, r_tmo_ticks}) begin
                        // idle timeout: release everything held
                        n_left     = r_cnt;
                        n_idx      = IW'(r_cnt - 1'b1);
                        n_tmo      = 1'b1;
                        n_rep_pend = 1'b0;
                        n_cnt      = '0;
                        n_idle     = '0;
                        n_state    = S_EMIT;
                    end else begin
                        n_idle = idle_inc[15:0];
                    end
                end
            end

            S_MATCH: begin
                // compare byte position j of every pattern against every live suffix
                for (int k = 0; k < MAX_LEN; k++) begin
                    for (int p = 0; p < NUM_PATTERNS; p++) begin
                        if (int'(r_j) <= k) begin
                            n_flag[k][p] = r_flag[k][p] && (r_win[k] == src_row[p]);
                        end
                    end
                end
                n_win[0] = '0;
                for (int k = 1; k < MAX_LEN; k++) begin
                    n_win[k] = r_win[k-1];
                end
                if (int'(r_j) == int'(r_len) - 1) begin
                    n_sz    = CW'(1);
                    n_found = 1'b0;
                    n_keep  = '0;
                    n_state = S_RES;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end

            S_RES: begin
                // walk suffix sizes upward: first full match wins, else track longest prefix
                for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
                    if (r_flag[k_sz][p] && (r_slen[p] == r_sz)) begin
                        any_full   = 1'b1;
                        first_full = PIW'(p);
                    end
                end
                if (any_full) begin
                    n_found = 1'b1;
                    n_hit   = first_full;
                    n_state = S_DEC;
                end else begin
                    if (|r_flag[k_sz]) begin
                        n_keep = r_sz;
                    end
                    if (r_sz == r_len) begin
                        n_state = S_DEC;
                    end else begin
                        n_sz = r_sz + 1'b1;
                    end
                end
            end

            S_DEC: begin
                if (r_found) begin
                    nlit   = r_len - r_sz;
                    rl     = r_rlen[r_hit];
                    newcnt = '0;
                end else begin
                    nlit   = r_len - r_keep;
                    rl     = '0;
                    newcnt = r_keep;
                end
                n_cnt      = newcnt;
                n_left     = nlit;
                n_idx      = IW'(r_len - 1'b1);
                n_tmo      = 1'b0;
                n_rep_pend = (rl != '0);
                n_rep_pat  = r_hit;
                n_rep_len  = rl;
                if ((nlit != '0) || (rl != '0) || (newcnt == '0)) begin
                    n_idle = '0;
                end
                if (nlit != '0) begin
                    n_state = S_EMIT;
                end else if (rl != '0) begin
                    n_state = S_REP;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_EMIT: begin
                // oldest held bytes first
                if (!i_q_full) begin
                    o_push      = 1'b1;
                    o_cmd.data  = r_buf[r_idx];
                    o_cmd.tmo   = r_tmo;
                    o_cmd.last  = (r_left == CW'(1)) && !r_rep_pend;
                    n_left      = r_left - 1'b1;
                    n_idx       = r_idx - 1'b1;
                    if (r_left == CW'(1)) begin
                        n_state = r_rep_pend ? S_REP : S_IDLE;
                    end
                end
            end

            S_REP: begin
                if (!i_q_full) begin
                    o_push       = 1'b1;
                    o_cmd.is_rep = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.pat    = PW'(r_rep_pat);
                    o_cmd.len    = LW'(r_rep_len);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idle  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idle  <= n_idle;
        end
    end

    // working data, no reset needed
    always_ff @(posedge i_clk) begin
        r_buf      <= n_buf;
        r_win      <= n_win;
        r_flag     <= n_flag;
        r_len      <= n_len;
        r_j        <= n_j;
        r_sz       <= n_sz;
        r_found    <= n_found;
        r_hit      <= n_hit;
        r_keep     <= n_keep;
        r_left     <= n_left;
        r_idx      <= n_idx;
        r_tmo      <= n_tmo;
        r_rep_pend <= n_rep_pend;
        r_rep_pat  <= n_rep_pat;
        r_rep_len  <= n_rep_len;
    end

    // configuration registers and pattern lengths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_tmo_ticks <= 16'd2;
            for (int p = 0; p < NUM_PATTERNS; p++) begin
                r_slen[p] <= CW'(1);
                r_rlen[p] <= '0;
            end
        end else begin
            if (i_cfg_valid && (i_cfg_index == spr_pkg::REG_PATTERN_COUNT)) begin
                r_pc <= (int'(i_cfg_data[2:0]) > NUM_PATTERNS) ? 3'(NUM_PATTERNS)
                                                                : i_cfg_data[2:0];
            end
            if (i_cfg_valid && (i_cfg_index == spr_pkg::REG_TIMEOUT)) begin
                r_tmo_ticks <= i_cfg_data;
            end
            if (acc && (i_func == spr_pkg::F_WR_LEN) &&
                (int'(i_pattern_index) < NUM_PATTERNS)) begin
                for (int p = 0; p < NUM_PATTERNS; p++) begin
                    if (int'(i_pattern_index) == p) begin
                        if (i_source_length == '0) begin
                            r_slen[p] <= CW'(1);
                        end else if (int'(i_source_length) > MAX_LEN) begin
                            r_slen[p] <= CW'(MAX_LEN);
                        end else begin
                            r_slen[p] <= CW'(i_source_length);
                        end
                        if (int'(i_replace_length) > MAX_LEN) begin
                            r_rlen[p] <= CW'(MAX_LEN);
                        end else begin
                            r_rlen[p] <= CW'(i_replace_length);
                        end
                    end
                end
            end
        end
    end

endmodule

/* hw/rtl/spr_back.sv */
// Back end: drains queued commands into the output register, expanding replacement runs.
module spr_back #(
    parameter int NUM_PATTERNS = 4,
    parameter int MAX_LEN      = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // command queue
    input  spr_pkg::t_cmd i_cmd,
    input  logic          i_q_empty,
    output logic          o_pop,
    output logic          o_idle,
    // replacement table read port
    output logic          o_rep_re,
    output logic [$clog2(NUM_PATTERNS*MAX_LEN)-1:0] o_rep_raddr,
    input  logic [7:0]    i_rep_rdata,
    // result channel
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_from_replacement,
    output logic          o_timeout_flush,
    output logic          o_is_last
);

    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int PIW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int RAW = $clog2(NUM_PATTERNS * MAX_LEN);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RD   = 2'd1;
    localparam logic [1:0] B_WR   = 2'd2;

    logic [1:0]     r_state;
    logic [PIW-1:0] r_pat;
    logic [CW-1:0]  r_len;
    logic [CW-1:0]  r_k;
    logic           r_last;
    logic           r_ov;
    logic [7:0]     r_ob;
    logic           r_ofr;
    logic           r_otmo;
    logic           r_olast;
    logic           slot_free;
    logic           run_end;

    assign slot_free   = !r_ov || i_out_ready;
    assign o_pop       = (r_state == B_IDLE) && !i_q_empty && slot_free;
    assign o_idle      = (r_state == B_IDLE) && i_q_empty;
    assign o_rep_re    = (r_state == B_RD);
    assign o_rep_raddr = RAW'(int'(r_pat) * MAX_LEN + int'(r_k));
    assign run_end     = (r_k == r_len - 1'b1);

    // command execution
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            // output register fills on a literal or a fetched replacement byte
            r_ov <= (o_pop && !i_cmd.is_rep) || ((r_state == B_WR) && slot_free) ||
                    (r_ov && !i_out_ready);
            case (r_state)
                B_IDLE: begin
                    if (o_pop && i_cmd.is_rep) begin
                        r_state <= B_RD;
                    end
                end
                B_RD: begin
                    r_state <= B_WR;
                end
                B_WR: begin
                    if (slot_free) begin
                        r_state <= run_end ? B_IDLE : B_RD;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    // payload of the output register and the run counters
    always_ff @(posedge i_clk) begin
        if ((r_state == B_IDLE) && o_pop) begin
            r_pat   <= PIW'(i_cmd.pat);
            r_len   <= CW'(i_cmd.len);
            r_k     <= '0;
            r_last  <= i_cmd.last;
            r_ob    <= i_cmd.data;
            r_ofr   <= 1'b0;
            r_otmo  <= i_cmd.tmo;
            r_olast <= i_cmd.last;
        end else if ((r_state == B_WR) && slot_free) begin
            r_ob    <= i_rep_rdata;
            r_ofr   <= 1'b1;
            r_otmo  <= 1'b0;
            r_olast <= r_last && run_end;
            r_k     <= r_k + 1'b1;
        end
    end

    assign o_out_valid        = r_ov;
    assign o_out_byte         = r_ob;
    assign o_from_replacement = r_ofr;
    assign o_timeout_flush    = r_otmo;
    assign o_is_last          = r_olast;

endmodule

/* hw/rtl/stream_pattern_replace.sv */
// Stream search-and-replace top level: front end, command queue, back end and replacement RAM.
//
// A data byte is held in a pending buffer of up to MAX_LEN bytes; the block then walks the
// source patterns one byte position per cycle (one row read from the per-pattern source RAMs,
// compared against every live suffix at once), then scans suffix sizes one per cycle to pick
// the shortest full match. A data byte therefore keeps the input side busy through these two
// scans, a decision step, the release of each literal byte and of a replacement run into the
// command queue, and while the queue is full. A tick that times out also releases every held
// byte into the queue. Output bytes drain from a 4-entry command queue: literals at one per
// cycle while the receiver is ready, replacement bytes through the registered read of the
// replacement RAM, a read state and a write state per byte. A replacement byte write waits
// until the back end has drained. Tables need no clearing after reset.
module stream_pattern_replace #(
    parameter int NUM_PATTERNS = 4,
    parameter int MAX_LEN      = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [2:0]                        i_func,
    input  logic [7:0]                        i_data_byte,
    input  logic [1:0]                        i_pattern_index,
    input  logic [3:0]                        i_byte_index,
    input  logic [4:0]                        i_source_length,
    input  logic [4:0]                        i_replace_length,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [spr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                       i_cfg_data,
    // results
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_out_byte,
    output logic                              o_from_replacement,
    output logic                              o_timeout_flush,
    output logic                              o_is_last
);

    localparam int RAW = $clog2(NUM_PATTERNS * MAX_LEN);

    logic               rep_we;
    logic [RAW-1:0]     rep_waddr;
    logic [7:0]         rep_wdata;
    logic               rep_re;
    logic [RAW-1:0]     rep_raddr;
    logic [7:0]         rep_rdata;
    logic               push;
    logic               pop;
    spr_pkg::t_cmd      cmd_in;
    spr_pkg::t_cmd      cmd_out;
    logic               q_full;
    logic               q_empty;
    logic               back_idle;

    assign o_cfg_ready = 1'b1;

    spr_front #(
        .NUM_PATTERNS (NUM_PATTERNS),
        .MAX_LEN      (MAX_LEN)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_data_byte      (i_data_byte),
        .i_pattern_index  (i_pattern_index),
        .i_byte_index     (i_byte_index),
        .i_source_length  (i_source_length),
        .i_replace_length (i_replace_length),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_rep_we         (rep_we),
        .o_rep_waddr      (rep_waddr),
        .o_rep_wdata      (rep_wdata),
        .o_push           (push),
        .o_cmd            (cmd_in),
        .i_q_full         (q_full),
        .i_back_idle      (back_idle)
    );

    spr_queue #(
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .i_pop   (pop),
        .o_data  (cmd_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // replacement pattern bytes, written by the front end, read by the back end
    spr_ram #(
        .WIDTH (8),
        .DEPTH (NUM_PATTERNS * MAX_LEN)
    ) u_rep_ram (
        .i_clk   (i_clk),
        .i_we    (rep_we),
        .i_waddr (rep_waddr),
        .i_wdata (rep_wdata),
        .i_re    (rep_re),
        .i_raddr (rep_raddr),
        .o_rdata (rep_rdata)
    );

    spr_back #(
        .NUM_PATTERNS (NUM_PATTERNS),
        .MAX_LEN      (MAX_LEN)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd_out),
        .i_q_empty          (q_empty),
        .o_pop              (pop),
        .o_idle             (back_idle),
        .o_rep_re           (rep_re),
        .o_rep_raddr        (rep_raddr),
        .i_rep_rdata        (rep_rdata),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_byte         (o_out_byte),
        .o_from_replacement (o_from_replacement),
        .o_timeout_flush    (o_timeout_flush),
        .o_is_last          (o_is_last)
    );

endmodule

/* dv/stream_pattern_replace_test.sv */
// Self-checking testbench for the stream pattern replacer: a scoreboard class predicts the byte stream.
module stream_pattern_replace_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPAT      = 4;
    localparam int MLEN      = 16;
    localparam int CYC_LIMIT = 600000;
    localparam int SETTLE    = 80;
    localparam int PER_PHASE = 42;
    localparam int HOLD_LEN  = 400;

    typedef struct {
        logic [7:0] val;
        logic       rep;
        logic       tmo;
        logic       last;
    } t_out_byte;

    // Predicts the output stream and checks what the block emits
    class t_replace_scoreboard;
        logic [7:0]  pend [MLEN];
        int unsigned held;
        logic [7:0]  src_tab [NPAT][MLEN];
        logic [7:0]  rep_tab [NPAT][MLEN];
        int unsigned src_len [NPAT];
        int unsigned rep_len [NPAT];
        int unsigned idle;
        int unsigned active;
        int unsigned tmo_limit;
        t_out_byte   due [$];
        int          errors;

        function new();
            held = 0;
            idle = 0;
            active = 0;
            tmo_limit = 2;
            errors = 0;
            for (int p = 0; p < NPAT; p++) begin
                src_len[p] = 1;
                rep_len[p] = 0;
            end
        endfunction

        function int outstanding();
            return due.size();
        endfunction

        function void apply_reg(logic [spr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == spr_pkg::REG_PATTERN_COUNT) begin
                active = (data[2:0] > NPAT) ? NPAT : data[2:0];
            end else if (idx == spr_pkg::REG_TIMEOUT) begin
                tmo_limit = data;
            end
        endfunction

        function void add_out(logic [7:0] b, logic rep, logic tmo);
            t_out_byte o;
            o.val = b;
            o.rep = rep;
            o.tmo = tmo;
            o.last = 1'b0;
            due.push_back(o);
        endfunction

        function bit suffix_matches(int unsigned s, int unsigned size, int unsigned p);
            for (int unsigned k = 0; k < size; k++) begin
                if (pend[s + k] != src_tab[p][k]) return 1'b0;
            end
            return 1'b1;
        endfunction

        // Append a stream byte, look for the shortest full match, release what is safe
        function void stream_byte(logic [7:0] b);
            int unsigned keep, hit_pos, hit_pat, size, start_cnt;
            bit found;
            start_cnt = due.size();
            found = 1'b0;
            hit_pos = 0;
            hit_pat = 0;
            if (held >= MLEN) held = MLEN - 1;
            pend[held] = b;
            held++;
            keep = held;
            for (int s = int'(held) - 1; s >= 0 && !found; s--) begin
                size = held - s;
                for (int unsigned p = 0; p < active; p++) begin
                    if (size <= src_len[p] && suffix_matches(s, size, p)) begin
                        if (size == src_len[p]) begin
                            found = 1'b1;
                            hit_pos = s;
                            hit_pat = p;
                            break;
                        end
                        keep = s;
                    end
                end
            end
            if (found) begin
                for (int unsigned k = 0; k < hit_pos; k++) add_out(pend[k], 1'b0, 1'b0);
                for (int unsigned k = 0; k < rep_len[hit_pat]; k++)
                    add_out(rep_tab[hit_pat][k], 1'b1, 1'b0);
                held = 0;
            end else begin
                for (int unsigned k = 0; k < keep; k++) add_out(pend[k], 1'b0, 1'b0);
                for (int unsigned k = keep; k < held; k++) pend[k - keep] = pend[k];
                held -= keep;
            end
            if (due.size() > start_cnt || held == 0) idle = 0;
        endfunction

        function void note_item(logic [2:0] fn, logic [7:0] db, logic [1:0] pi,
                                logic [3:0] bi, logic [4:0] sl, logic [4:0] rl);
            int unsigned start_cnt;
            start_cnt = due.size();
            case (fn)
                spr_pkg::F_DATA: stream_byte(db);
                spr_pkg::F_WR_SRC: src_tab[pi][bi] = db;
                spr_pkg::F_WR_REP: rep_tab[pi][bi] = db;
                spr_pkg::F_WR_LEN: begin
                    src_len[pi] = (sl == 0) ? 1 : ((sl > MLEN) ? MLEN : sl);
                    rep_len[pi] = (rl > MLEN) ? MLEN : rl;
                end
                spr_pkg::F_TICK: begin
                    if (tmo_limit == 0 || held == 0) begin
                        idle = 0;
                    end else begin
                        idle++;
                        if (idle >= tmo_limit) begin
                            for (int unsigned k = 0; k < held; k++) add_out(pend[k], 1'b0, 1'b1);
                            held = 0;
                            idle = 0;
                        end
                    end
                end
                default: ;
            endcase
            if (due.size() > start_cnt) due[due.size() - 1].last = 1'b1;
        endfunction

        function void check_byte(logic [7:0] b, logic rep, logic tmo, logic last);
            t_out_byte e;
            if (due.size() == 0) begin
                $error("unexpected output byte %0h", b);
                errors++;
                return;
            end
            e = due.pop_front();
            if (b !== e.val) begin
                $error("out_byte expected %0h got %0h", e.val, b);
                errors++;
            end
            if (rep !== e.rep) begin
                $error("from_replacement expected %0b got %0b", e.rep, rep);
                errors++;
            end
            if (tmo !== e.tmo) begin
                $error("timeout_flush expected %0b got %0b", e.tmo, tmo);
                errors++;
            end
            if (last !== e.last) begin
                $error("is_last expected %0b got %0b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_func = spr_pkg::F_DATA;
    logic [7:0]  i_data_byte = '0;
    logic [1:0]  i_pattern_index = '0;
    logic [3:0]  i_byte_index = '0;
    logic [4:0]  i_source_length = 5'd1;
    logic [4:0]  i_replace_length = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [spr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_from_replacement;
    logic        o_timeout_flush;
    logic        o_is_last;

    t_replace_scoreboard sb = new();
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  cycles = 0;

    stream_pattern_replace dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("FAIL stream_pattern_replace");
            $finish;
        end
    end

    // Receiver: check each transfer, then pick next ready (random stalls, one long hold)
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_byte(o_out_byte, o_from_replacement, o_timeout_flush, o_is_last);
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_item(logic [2:0] fn, logic [7:0] db, logic [1:0] pi,
                             logic [3:0] bi, logic [4:0] sl, logic [4:0] rl);
        if ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_data_byte <= db;
        i_pattern_index <= pi;
        i_byte_index <= bi;
        i_source_length <= sl;
        i_replace_length <= rl;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(fn, db, pi, bi, sl, rl);
    endtask

    task automatic write_reg(logic [spr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.apply_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering, let every expected byte arrive, then cover the no-result tail
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Small alphabet so the stream often meets the patterns
    function automatic logic [7:0] near_byte();
        return ($urandom_range(9) < 8) ? 8'h41 + 8'($urandom_range(2)) : 8'($urandom);
    endfunction

    task automatic random_item();
        int sel;
        sel = $urandom_range(99);
        if (sel < 62)
            send_item(spr_pkg::F_DATA, near_byte(), 2'($urandom), 4'($urandom),
                      5'($urandom), 5'($urandom));
        else if (sel < 82)
            send_item(spr_pkg::F_TICK, 8'($urandom), 2'($urandom), 4'($urandom),
                      5'($urandom), 5'($urandom));
        else if (sel < 88)
            send_item(spr_pkg::F_WR_SRC, near_byte(), 2'($urandom), 4'($urandom),
                      5'($urandom), 5'($urandom));
        else if (sel < 92)
            send_item(spr_pkg::F_WR_REP, 8'($urandom), 2'($urandom), 4'($urandom),
                      5'($urandom), 5'($urandom));
        else if (sel < 97)
            send_item(spr_pkg::F_WR_LEN, 8'($urandom), 2'($urandom), 4'($urandom),
                      ($urandom_range(1)) ? 5'($urandom_range(1, 4)) : 5'($urandom),
                      5'($urandom));
        else
            send_item(spr_pkg::F_TICK + 3'($urandom_range(1, 3)), 8'($urandom),
                      2'($urandom), 4'($urandom), 5'($urandom), 5'($urandom));
    endtask

    initial begin
        int pcount [5] = '{4, 2, 7, 1, 3};
        int tmo    [5] = '{3, 1, 0, 65535, 2};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill both tables so no unwritten entry is ever read
        for (int p = 0; p < NPAT; p++) begin
            for (int k = 0; k < MLEN; k++) begin
                send_item(spr_pkg::F_WR_SRC, near_byte(), 2'(p), 4'(k),
                          5'($urandom), 5'($urandom));
                send_item(spr_pkg::F_WR_REP, 8'($urandom), 2'(p), 4'(k),
                          5'($urandom), 5'($urandom));
            end
        end
        // No patterns active yet: bytes pass straight through
        send_item(spr_pkg::F_DATA, 8'h00, 2'd0, 4'd0, 5'd0, 5'd0);
        send_item(spr_pkg::F_DATA, 8'hFF, 2'd3, 4'd15, 5'd31, 5'd31);
        drain();

        // Directed: extremes of lengths, saturation, ticks to timeout, unknown funcs
        write_reg(spr_pkg::REG_PATTERN_COUNT, 16'd4);
        write_reg(spr_pkg::REG_TIMEOUT, 16'd3);
        send_item(spr_pkg::F_WR_LEN, 8'h00, 2'd0, 4'd0, 5'd2, 5'd3);
        send_item(spr_pkg::F_WR_LEN, 8'hFF, 2'd1, 4'd15, 5'd0, 5'd0);
        send_item(spr_pkg::F_WR_LEN, 8'h00, 2'd2, 4'd0, 5'd31, 5'd31);
        send_item(spr_pkg::F_WR_LEN, 8'h00, 2'd3, 4'd0, 5'd16, 5'd16);
        for (int k = 0; k < 6; k++)
            send_item(spr_pkg::F_DATA, near_byte(), 2'd0, 4'd0, 5'd0, 5'd0);
        send_item(spr_pkg::F_DATA, 8'h00, 2'd0, 4'd0, 5'd0, 5'd0);
        send_item(spr_pkg::F_DATA, 8'hFF, 2'd0, 4'd0, 5'd0, 5'd0);
        send_item(spr_pkg::F_DATA, 8'h41, 2'd0, 4'd0, 5'd0, 5'd0);
        for (int k = 0; k < 4; k++)
            send_item(spr_pkg::F_TICK, 8'h00, 2'd0, 4'd0, 5'd0, 5'd0);
        send_item(spr_pkg::F_TICK + 3'd1, 8'hFF, 2'd3, 4'd15, 5'd31, 5'd31);
        send_item(spr_pkg::F_TICK + 3'd2, 8'h00, 2'd0, 4'd0, 5'd0, 5'd0);
        send_item(spr_pkg::F_TICK + 3'd3, 8'h00, 2'd0, 4'd0, 5'd0, 5'd0);
        send_item(spr_pkg::F_WR_LEN, 8'h00, 2'd1, 4'd0, 5'd1, 5'd2);

        // Random phases under different settings and idling
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_reg(spr_pkg::REG_PATTERN_COUNT, {13'($urandom), 3'(pcount[ph])});
            write_reg(spr_pkg::REG_TIMEOUT, 16'(tmo[ph]));
            send_idle <= (ph < 2) ? 9 : ((ph == 2) ? 45 : 0);
            recv_idle <= (ph < 2) ? 45 : ((ph == 2) ? 9 : 0);
            if (ph == 3) hold_req <= 1'b1;
            for (int n = 0; n < PER_PHASE; n++) random_item();
        end
        drain();

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASS stream_pattern_replace");
        end else begin
            $display("FAIL stream_pattern_replace");
        end
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/spr_pkg.sv
hw/rtl/spr_ram.sv
hw/rtl/spr_queue.sv
hw/rtl/spr_front.sv
hw/rtl/spr_back.sv
hw/rtl/stream_pattern_replace.sv
dv/stream_pattern_replace_test.sv
